FILE: hw/rtl/sicv_pkg.sv
// Shared types, length codes and opcode tables for the SIC/XE instruction validator.
// No dependencies; used by sicv_check and the sicxe_instruction_validator top level.
`timescale 1ns / 1ps

package sicv_pkg;

    localparam int INSTR_W = 32;
    localparam int DIGITS_W = 4;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    // Instruction length in hex digits per format
    localparam logic [DIGITS_W-1:0] LEN_FMT1 = 4'd2;
    localparam logic [DIGITS_W-1:0] LEN_FMT2 = 4'd4;
    localparam logic [DIGITS_W-1:0] LEN_FMT3 = 4'd6;
    localparam logic [DIGITS_W-1:0] LEN_FMT4 = 4'd8;

    // Format numbers reported on the result
    localparam logic [2:0] FMT_NONE = 3'd0;
    localparam logic [2:0] FMT_1    = 3'd1;
    localparam logic [2:0] FMT_2    = 3'd2;
    localparam logic [2:0] FMT_3    = 3'd3;
    localparam logic [2:0] FMT_4    = 3'd4;

    // n,i addressing codes
    localparam logic [1:0] NI_SIC    = 2'd0;
    localparam logic [1:0] NI_SIMPLE = 2'd3;

    typedef struct packed {
        logic       valid_res;
        logic [2:0] format_num;
        logic       length_error;
        logic       opcode_error;
        logic       reg1_error;
        logic       reg2_error;
        logic       ext_error;
        logic       bp_error;
        logic       index_error;
        logic       mode_error;
        logic [1:0] addr_type;
        logic [3:0] xbpe_bits;
    } result_t;

    // Format 3/4 opcodes, n,i bits cleared
    function automatic logic is_xe_op(input logic [7:0] op);
        logic hit;
        hit = 1'b0;
        case (op) inside
            8'h18, 8'h58, 8'h40, 8'h28, 8'h88, 8'h24, 8'h64, 8'h3C, 8'h30, 8'h34,
            8'h38, 8'h48, 8'h00, 8'h68, 8'h50, 8'h70, 8'h08, 8'h6C, 8'h74, 8'h04,
            8'hD0, 8'h20, 8'h60, 8'h44, 8'hD8, 8'h4C, 8'hEC, 8'h0C, 8'h78, 8'h54,
            8'h80, 8'hD4, 8'h14, 8'h7C, 8'hE8, 8'h84, 8'h10, 8'h1C, 8'h5C, 8'hE0,
            8'h2C, 8'hDC: hit = 1'b1;
            default:      hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Plain SIC opcodes (n=i=0)
    function automatic logic is_sic_op(input logic [7:0] op);
        logic hit;
        hit = 1'b0;
        case (op) inside
            8'h18, 8'h40, 8'h28, 8'h24, 8'h3C, 8'h30, 8'h34, 8'h38, 8'h48, 8'h00,
            8'h50, 8'h08, 8'h04, 8'h20, 8'h44, 8'hD8, 8'h4C, 8'h0C, 8'h54, 8'h14,
            8'hE8, 8'h10, 8'h1C, 8'hE0, 8'h2C, 8'hDC: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic is_fmt1_op(input logic [7:0] op);
        logic hit;
        hit = 1'b0;
        case (op) inside
            8'hC0, 8'hC4, 8'hC8, 8'hF0, 8'hF4, 8'hF8: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic is_fmt2_op(input logic [7:0] op);
        logic hit;
        hit = 1'b0;
        case (op) inside
            8'h90, 8'hB4, 8'hA0, 8'h9C, 8'h98, 8'hAC, 8'hA4, 8'hA8, 8'h94, 8'hB0,
            8'hB8: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Register numbers 0-6, 8 and 9 exist
    function automatic logic reg_ok(input logic [3:0] r);
        return (r <= 4'd6) || (r == 4'd8) || (r == 4'd9);
    endfunction

endpackage

FILE: hw/rtl/sicv_check.sv
// Combinational format, opcode and flag checks for one SIC/XE instruction word.
// Depends on sicv_pkg for the result type, length codes and opcode tables.
`timescale 1ns / 1ps

module sicv_check (
    input  logic [sicv_pkg::INSTR_W-1:0]  instr_word,
    input  logic [sicv_pkg::DIGITS_W-1:0] hex_digits,
    output sicv_pkg::result_t             result
);
    import sicv_pkg::*;

    logic [7:0] opc;
    logic [1:0] ni;
    logic [3:0] xbpe;
    logic       is_long;

    // Pick the opcode byte and flag nibble for formats 3 and 4
    always_comb begin
        is_long = (hex_digits == LEN_FMT4);
        opc     = is_long ? instr_word[31:24] : instr_word[23:16];
        xbpe    = is_long ? instr_word[23:20] : instr_word[15:12];
        ni      = opc[1:0];
    end

    // Per-format checks; anything not set stays zero
    always_comb begin
        result = '0;
        unique case (hex_digits)
            LEN_FMT1: begin
                result.format_num   = FMT_1;
                result.opcode_error = !is_fmt1_op(instr_word[7:0]);
            end
            LEN_FMT2: begin
                result.format_num   = FMT_2;
                result.opcode_error = !is_fmt2_op(instr_word[15:8]);
                result.reg1_error   = !reg_ok(instr_word[7:4]);
                result.reg2_error   = !reg_ok(instr_word[3:0]);
            end
            LEN_FMT3: begin
                result.format_num = FMT_3;
                result.addr_type  = ni;
                result.xbpe_bits  = xbpe;
                result.ext_error  = xbpe[0];
                if (ni == NI_SIC) begin
                    result.opcode_error = !is_sic_op(opc);
                end else begin
                    result.opcode_error = !is_xe_op({opc[7:2], 2'b00});
                    result.bp_error     = xbpe[2] & xbpe[1];
                    result.index_error  = (ni != NI_SIMPLE) & xbpe[3];
                end
            end
            LEN_FMT4: begin
                result.format_num = FMT_4;
                result.addr_type  = ni;
                result.xbpe_bits  = xbpe;
                result.ext_error  = !xbpe[0];
                result.bp_error   = xbpe[2] | xbpe[1];
                if (ni == NI_SIC) begin
                    // extended form has no SIC mode
                    result.mode_error = 1'b1;
                end else begin
                    result.opcode_error = !is_xe_op({opc[7:2], 2'b00});
                    result.index_error  = (ni != NI_SIMPLE) & xbpe[3];
                end
            end
            default: begin
                result.format_num   = FMT_NONE;
                result.length_error = 1'b1;
            end
        endcase
        result.valid_res = !(result.length_error | result.opcode_error | result.reg1_error
                             | result.reg2_error | result.ext_error | result.bp_error
                             | result.index_error | result.mode_error);
    end

endmodule

FILE: hw/rtl/sicxe_instruction_validator.sv
// Top level of the SIC/XE instruction validator: input register, checks, result register.
// Depends on sicv_pkg and sicv_check.
`timescale 1ns / 1ps

// One instruction word goes in per item and one result comes out per item, in order.
// An item is held first in the input register and then in the result register, with
// the format and opcode checks between them. The block takes a new item every cycle
// while the result side keeps up. When the result side stalls,
// s_tready drops in the same cycle if the input register holds an item; only an
// empty input register still takes one more item before s_tready drops.
// There is no state beyond the two pipeline registers.
module sicxe_instruction_validator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] instr_word, [35:32] hex_digits, [39:36] zero
    input  logic [sicv_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] valid_res, [3:1] format_num, [4] length_error, [5] opcode_error,
    // [6] reg1_error, [7] reg2_error, [8] ext_error, [9] bp_error,
    // [10] index_error, [11] mode_error, [13:12] addr_type, [17:14] xbpe_bits,
    // [23:18] zero
    output logic [sicv_pkg::M_TDATA_W-1:0] m_tdata
);
    import sicv_pkg::*;

    logic                in_valid_reg;
    logic [INSTR_W-1:0]  word_reg;
    logic [DIGITS_W-1:0] digits_reg;
    logic                out_valid_reg;
    result_t             res_reg;
    result_t             res_next;
    logic                out_load;
    logic                in_load;

    // Result register loads when empty or being drained
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    sicv_check u_check (
        .instr_word (word_reg),
        .hex_digits (digits_reg),
        .result     (res_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (in_load) begin
            word_reg   <= s_tdata[INSTR_W-1:0];
            digits_reg <= s_tdata[INSTR_W+DIGITS_W-1:INSTR_W];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
        if (out_load && in_valid_reg) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, res_reg.xbpe_bits, res_reg.addr_type, res_reg.mode_error,
                       res_reg.index_error, res_reg.bp_error, res_reg.ext_error,
                       res_reg.reg2_error, res_reg.reg1_error, res_reg.opcode_error,
                       res_reg.length_error, res_reg.format_num, res_reg.valid_res};

endmodule
